/* rtl/dacia_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual ACIA package
// Shared constants, request and result-source codes, and the status byte
// builder for the two-channel serial block.
// ----------------------------------------------------------------------------
package dacia_pkg;

   localparam int FIFO_DEPTH_DEF   = 16;
   localparam int NUM_CHANNELS_DEF = 2;

   localparam logic [7:0] BASE_PORT_RESET = 8'h10;

   // control register encoding
   localparam logic [7:0] CTRL_RESET_MASK = 8'h03;
   localparam int         CTRL_RXIE_BIT   = 7;
   localparam logic [7:0] CTRL_TXIE_MASK  = 8'h60;
   localparam logic [7:0] CTRL_TXIE_VALUE = 8'h20;

   // status register bit positions
   localparam int ST_RDRF_BIT = 0;
   localparam int ST_TDRE_BIT = 1;
   localparam int ST_OVRN_BIT = 5;
   localparam int ST_IRQ_BIT  = 7;

   localparam logic [7:0] UNOWNED_DATA = 8'hFF;

   typedef enum logic [1:0] {
      REQ_BUS_READ  = 2'd0,
      REQ_BUS_WRITE = 2'd1,
      REQ_HOST_SEND = 2'd2,
      REQ_HOST_TAKE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      SRC_CALC = 2'd0,
      SRC_RX   = 2'd1,
      SRC_TX   = 2'd2
   } src_type;

   function automatic logic [7:0] status_byte(input logic rdrf, input logic tdre,
                                              input logic ovrn, input logic rxie,
                                              input logic txie);
      logic [7:0] s;
      s              = '0;
      s[ST_RDRF_BIT] = rdrf;
      s[ST_TDRE_BIT] = tdre;
      s[ST_OVRN_BIT] = ovrn;
      s[ST_IRQ_BIT]  = (rxie & rdrf) | (txie & tdre);
      return s;
   endfunction

endpackage

/* rtl/dacia_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual ACIA byte store
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dacia_ram #(
   parameter int DEPTH = dacia_pkg::FIFO_DEPTH_DEF * dacia_pkg::NUM_CHANNELS_DEF,
   parameter int WIDTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dual_acia_serial_with_fifos.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual ACIA serial block with FIFOs
// Two 6850-style channels on four bus ports, each with receive and transmit
// byte FIFOs fed and drained by a host side.
// ----------------------------------------------------------------------------
// A response passes the stage-1 register, then the response register;
// rsp_stall can hold both. Throughput: one request per cycle unless stalled;
// FIFO pointers and status decode settle at accept; memory read is in stage 1.
// Reset (synchronous): clears pointers, fill counts, overrun, interrupt
// enables and both pipeline valids; base_port returns to 0x10. FIFO byte
// storage is not cleared, so the block is ready the cycle after reset.
module dual_acia_serial_with_fifos #(
   parameter int FIFO_DEPTH   = dacia_pkg::FIFO_DEPTH_DEF,
   parameter int NUM_CHANNELS = dacia_pkg::NUM_CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_port,
   input  logic       req_channel,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_ok,
   output logic       rsp_irq_pulse,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_CHANNELS * FIFO_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   localparam logic [7:0]        PORT_SPAN = 8'(2 * NUM_CHANNELS);
   localparam logic [CNT_W-1:0]  FIFO_FULL = CNT_W'(FIFO_DEPTH);
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [ADDR_W-1:0] CH1_BASE  = ADDR_W'(FIFO_DEPTH);

   // configuration and per-channel state
   logic [7:0]       base_port_ff;
   logic [PTR_W-1:0] rx_head_ff [NUM_CHANNELS];
   logic [PTR_W-1:0] rx_head_in [NUM_CHANNELS];
   logic [CNT_W-1:0] rx_fill_ff [NUM_CHANNELS];
   logic [CNT_W-1:0] rx_fill_in [NUM_CHANNELS];
   logic [PTR_W-1:0] tx_head_ff [NUM_CHANNELS];
   logic [PTR_W-1:0] tx_head_in [NUM_CHANNELS];
   logic [CNT_W-1:0] tx_fill_ff [NUM_CHANNELS];
   logic [CNT_W-1:0] tx_fill_in [NUM_CHANNELS];
   logic             ovrn_ff    [NUM_CHANNELS];
   logic             ovrn_in    [NUM_CHANNELS];
   logic             rxie_ff    [NUM_CHANNELS];
   logic             rxie_in    [NUM_CHANNELS];
   logic             txie_ff    [NUM_CHANNELS];
   logic             txie_in    [NUM_CHANNELS];

   // stage 1: decoded request plus registered memory read
   logic              s1_vld_ff;
   logic              s1_vld_in;
   dacia_pkg::src_type s1_src_ff;
   dacia_pkg::src_type s1_src_in;
   logic [7:0]        s1_rd_ff;
   logic [7:0]        s1_rd_in;
   logic              s1_ok_ff;
   logic              s1_ok_in;
   logic              s1_irq_ff;
   logic              s1_irq_in;
   logic              s1_move;

   // stage 2: response register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_read_data_ff;
   logic [7:0] rsp_read_data_in;
   logic       rsp_ok_ff;
   logic       rsp_irq_ff;

   // decode
   dacia_pkg::req_kind_type req_kind;
   logic             req_acc;
   logic [7:0]       port_off;
   logic             in_block;
   logic             off_data;
   logic             host_ch_ok;
   logic             act_ch;
   logic [PTR_W-1:0] sel_rx_head;
   logic [CNT_W-1:0] sel_rx_fill;
   logic [PTR_W-1:0] sel_tx_head;
   logic [CNT_W-1:0] sel_tx_fill;
   logic             sel_ovrn;
   logic             sel_rxie;
   logic             sel_txie;
   logic             rx_nz;
   logic             rx_room;
   logic             tx_nz;
   logic             tx_room;
   logic             master_rst;
   logic             op_rx_pop;
   logic             op_ctrl;
   logic             op_tx_push;
   logic             op_rx_push;
   logic             op_rx_ovf;
   logic             op_tx_pop;
   logic             wr_irq;
   logic [ADDR_W-1:0] chan_base;
   logic [ADDR_W-1:0] rx_waddr;
   logic [ADDR_W-1:0] rx_raddr;
   logic [ADDR_W-1:0] tx_waddr;
   logic [ADDR_W-1:0] tx_raddr;
   logic [7:0]        rx_q;
   logic [7:0]        tx_q;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_tail(input logic [PTR_W-1:0] h,
                                                  input logic [CNT_W-1:0] f);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(h) + (CNT_W + 1)'(f);
      if (sum >= (CNT_W + 1)'(FIFO_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(FIFO_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   assign req_kind   = dacia_pkg::req_kind_type'(req_type);
   assign s1_move    = s1_vld_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_vld_ff & ~s1_move;
   assign req_acc    = req_valid & ~req_stall;
   assign port_off   = req_port - base_port_ff;
   assign in_block   = port_off < PORT_SPAN;
   assign off_data   = port_off[0];
   assign host_ch_ok = int'(req_channel) < NUM_CHANNELS;
   assign act_ch     = (req_kind == dacia_pkg::REQ_BUS_READ ||
                        req_kind == dacia_pkg::REQ_BUS_WRITE) ? port_off[1] : req_channel;

   always_comb begin
      sel_rx_head = '0;
      sel_rx_fill = '0;
      sel_tx_head = '0;
      sel_tx_fill = '0;
      sel_ovrn    = 1'b0;
      sel_rxie    = 1'b0;
      sel_txie    = 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (act_ch == 1'(c)) begin
            sel_rx_head = rx_head_ff[c];
            sel_rx_fill = rx_fill_ff[c];
            sel_tx_head = tx_head_ff[c];
            sel_tx_fill = tx_fill_ff[c];
            sel_ovrn    = ovrn_ff[c];
            sel_rxie    = rxie_ff[c];
            sel_txie    = txie_ff[c];
         end
      end
   end

   assign rx_nz   = sel_rx_fill != '0;
   assign rx_room = sel_rx_fill != FIFO_FULL;
   assign tx_nz   = sel_tx_fill != '0;
   assign tx_room = sel_tx_fill != FIFO_FULL;

   assign master_rst = (req_data & dacia_pkg::CTRL_RESET_MASK) == dacia_pkg::CTRL_RESET_MASK;

   assign op_rx_pop  = req_acc & (req_kind == dacia_pkg::REQ_BUS_READ) & in_block & off_data
                       & rx_nz;
   assign op_ctrl    = req_acc & (req_kind == dacia_pkg::REQ_BUS_WRITE) & in_block & ~off_data;
   assign op_tx_push = req_acc & (req_kind == dacia_pkg::REQ_BUS_WRITE) & in_block & off_data
                       & tx_room;
   assign op_rx_push = req_acc & (req_kind == dacia_pkg::REQ_HOST_SEND) & host_ch_ok & rx_room;
   assign op_rx_ovf  = req_acc & (req_kind == dacia_pkg::REQ_HOST_SEND) & host_ch_ok & ~rx_room;
   assign op_tx_pop  = req_acc & (req_kind == dacia_pkg::REQ_HOST_TAKE) & host_ch_ok & tx_nz;

   // next channel state
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         rx_head_in[c] = rx_head_ff[c];
         rx_fill_in[c] = rx_fill_ff[c];
         tx_head_in[c] = tx_head_ff[c];
         tx_fill_in[c] = tx_fill_ff[c];
         ovrn_in[c]    = ovrn_ff[c];
         rxie_in[c]    = rxie_ff[c];
         txie_in[c]    = txie_ff[c];
         if (act_ch == 1'(c)) begin
            if (op_rx_pop) begin
               rx_head_in[c] = ptr_next(rx_head_ff[c]);
               rx_fill_in[c] = rx_fill_ff[c] - CNT_W'(1);
               ovrn_in[c]    = 1'b0;
            end
            if (op_rx_push) begin
               rx_fill_in[c] = rx_fill_ff[c] + CNT_W'(1);
            end
            if (op_rx_ovf) begin
               ovrn_in[c] = 1'b1;
            end
            if (op_tx_push) begin
               tx_fill_in[c] = tx_fill_ff[c] + CNT_W'(1);
            end
            if (op_tx_pop) begin
               tx_head_in[c] = ptr_next(tx_head_ff[c]);
               tx_fill_in[c] = tx_fill_ff[c] - CNT_W'(1);
            end
            if (op_ctrl) begin
               if (master_rst) begin
                  ovrn_in[c] = 1'b0;
                  rxie_in[c] = 1'b0;
                  txie_in[c] = 1'b0;
               end else begin
                  rxie_in[c] = req_data[dacia_pkg::CTRL_RXIE_BIT];
                  txie_in[c] = (req_data & dacia_pkg::CTRL_TXIE_MASK)
                               == dacia_pkg::CTRL_TXIE_VALUE;
               end
            end
         end
      end
   end

   // a data write reports the interrupt line as it stands after the push
   always_comb begin
      logic [7:0] st;
      wr_irq = 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         st = dacia_pkg::status_byte(rx_fill_in[c] != '0, tx_fill_in[c] != FIFO_FULL,
                                     ovrn_in[c], rxie_in[c], txie_in[c]);
         wr_irq = wr_irq | st[dacia_pkg::ST_IRQ_BIT];
      end
   end

   always_comb begin
      s1_src_in = dacia_pkg::SRC_CALC;
      s1_rd_in  = '0;
      s1_ok_in  = 1'b0;
      s1_irq_in = 1'b0;
      case (req_kind)
         dacia_pkg::REQ_BUS_READ: begin
            if (!in_block) begin
               s1_rd_in = dacia_pkg::UNOWNED_DATA;
            end else if (!off_data) begin
               s1_rd_in = dacia_pkg::status_byte(rx_nz, tx_room, sel_ovrn, sel_rxie, sel_txie);
            end else if (rx_nz) begin
               s1_src_in = dacia_pkg::SRC_RX;
            end
         end
         dacia_pkg::REQ_BUS_WRITE: begin
            s1_irq_in = in_block & off_data & wr_irq;
         end
         dacia_pkg::REQ_HOST_SEND: begin
            s1_ok_in  = host_ch_ok & rx_room;
            s1_irq_in = host_ch_ok & rx_room & sel_rxie;
         end
         dacia_pkg::REQ_HOST_TAKE: begin
            if (host_ch_ok && tx_nz) begin
               s1_ok_in  = 1'b1;
               s1_src_in = dacia_pkg::SRC_TX;
            end
         end
         default: begin
            s1_src_in = dacia_pkg::SRC_CALC;
         end
      endcase
   end

   assign chan_base = act_ch ? CH1_BASE : '0;
   assign rx_waddr  = chan_base + ADDR_W'(ptr_tail(sel_rx_head, sel_rx_fill));
   assign rx_raddr  = chan_base + ADDR_W'(sel_rx_head);
   assign tx_waddr  = chan_base + ADDR_W'(ptr_tail(sel_tx_head, sel_tx_fill));
   assign tx_raddr  = chan_base + ADDR_W'(sel_tx_head);

   dacia_ram #(
      .DEPTH (MEM_DEPTH),
      .WIDTH (8)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (op_rx_push),
      .wr_addr (rx_waddr),
      .wr_data (req_data),
      .rd_en   (op_rx_pop),
      .rd_addr (rx_raddr),
      .rd_data (rx_q)
   );

   dacia_ram #(
      .DEPTH (MEM_DEPTH),
      .WIDTH (8)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (op_tx_push),
      .wr_addr (tx_waddr),
      .wr_data (req_data),
      .rd_en   (op_tx_pop),
      .rd_addr (tx_raddr),
      .rd_data (tx_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_port_ff <= dacia_pkg::BASE_PORT_RESET;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            rx_head_ff[c] <= '0;
            rx_fill_ff[c] <= '0;
            tx_head_ff[c] <= '0;
            tx_fill_ff[c] <= '0;
            ovrn_ff[c]    <= 1'b0;
            rxie_ff[c]    <= 1'b0;
            txie_ff[c]    <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            base_port_ff <= csr_wdata;
         end
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            rx_head_ff[c] <= rx_head_in[c];
            rx_fill_ff[c] <= rx_fill_in[c];
            tx_head_ff[c] <= tx_head_in[c];
            tx_fill_ff[c] <= tx_fill_in[c];
            ovrn_ff[c]    <= ovrn_in[c];
            rxie_ff[c]    <= rxie_in[c];
            txie_ff[c]    <= txie_in[c];
         end
      end
   end

   // pipeline control
   assign s1_vld_in    = req_acc | (s1_vld_ff & ~s1_move);
   assign rsp_valid_in = s1_move | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_src_ff <= s1_src_in;
         s1_rd_ff  <= s1_rd_in;
         s1_ok_ff  <= s1_ok_in;
         s1_irq_ff <= s1_irq_in;
      end
   end

   always_comb begin
      case (s1_src_ff)
         dacia_pkg::SRC_RX: rsp_read_data_in = rx_q;
         dacia_pkg::SRC_TX: rsp_read_data_in = tx_q;
         default:           rsp_read_data_in = s1_rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_ok_ff        <= s1_ok_ff;
         rsp_irq_ff       <= s1_irq_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_irq_pulse = rsp_irq_ff;

   // stall only while both stages are full and the output is held
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_vld_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // a held stage-1 request is not dropped
   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && rsp_valid_ff && rsp_stall) |=> s1_vld_ff)
      else $error("stage-1 request lost while output stalled");

   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_fill_chk
      a_fill_bound : assert property (@(posedge clock) disable iff (reset)
         (rx_fill_ff[g] <= FIFO_FULL) && (tx_fill_ff[g] <= FIFO_FULL))
         else $error("FIFO fill count beyond depth");
   end

endmodule
